FILE: rtl/dtpq_pkg.sv
package dtpq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 20;
  localparam int unsigned SEEN_DEPTH_DEF  = 40;

  localparam int unsigned ID_W     = 64;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned DBM_W    = 9;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEVEL_W  = 5;

  // Input tdata: msg_id, id_valid, urgent, payload_tag, signal_dbm, zero fill.
  localparam int unsigned IN_DATA_W  = 96;
  // Output tdata: out_id, out_id_valid, out_urgent, out_tag, out_dbm,
  // queue_level, head_urgent, zero fill.
  localparam int unsigned OUT_DATA_W = 104;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED      = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_EVICTED     = 3'd2,
    ST_NEW_DROPPED = 3'd3,
    ST_POPPED      = 3'd4,
    ST_EMPTY       = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_e;

  // One queued message, as held by a queue cell.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             idv;
    logic             urg;
    logic [TAG_W-1:0] tag;
    logic [DBM_W-1:0] dbm;
  } entry_t;

  // Per-cell move control of the queue row.
  typedef struct packed {
    logic load_new;
    logic take_prev;
    logic take_next;
  } qcell_ctl_t;

endpackage

FILE: rtl/dedup_two_class_priority_queue.sv
// Duplicate filter in front of a two-class priority queue. Each input item is
// either a receive (tuser = 0) or a pop request (tuser = 1). A received
// message whose ID matches one of the last SEEN_DEPTH recorded IDs is dropped;
// otherwise its ID (if present) enters the seen window, an urgent message is
// placed behind the last urgent one and a normal one at the tail, and if the
// queue overflows QUEUE_DEPTH the tail item is evicted (possibly the new one).
// A pop returns the head item or reports an empty queue. Every input item
// yields exactly one result item. An item is handled in an accept cycle and
// an update cycle: in the accept cycle every seen-window cell compares its ID
// against the incoming one and registers a hit, and in the following cycle
// the hits are combined and the queue row and seen row shift in one step. A
// new item is accepted only back in the idle state, and only while no result
// is pending or the result side takes the pending one. The queue and seen
// window are rows of cells that pass entries to their neighbors; no clearing
// pass is needed after reset.
module dedup_two_class_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = dtpq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned SEEN_DEPTH  = dtpq_pkg::SEEN_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] msg_id, [64] id_valid, [65] urgent, [81:66] payload_tag,
  // [90:82] signal_dbm, [95:91] zero
  input  logic [dtpq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] op
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] out_id, [64] out_id_valid, [65] out_urgent, [81:66] out_tag,
  // [90:82] out_dbm, [95:91] queue_level, [96] head_urgent, [103:97] zero
  output logic [dtpq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [2:0] status
  output logic [dtpq_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SCW = $clog2(SEEN_DEPTH + 1);

  // Control state
  dtpq_pkg::state_e  state_q, state_d;
  logic [QCW-1:0]    qcnt_q, qcnt_d;
  logic [QCW-1:0]    ucnt_q, ucnt_d;
  logic [SCW-1:0]    scnt_q, scnt_d;
  logic              out_valid_q, out_valid_d;

  // Held input item and result
  dtpq_pkg::entry_t  in_q;
  dtpq_pkg::op_e     op_q;
  logic [dtpq_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  dtpq_pkg::status_e               status_q, status_d;

  logic in_fire;
  logic upd;

  // Rows
  logic [dtpq_pkg::ID_W-1:0] seen_id [SEEN_DEPTH];
  logic [SEEN_DEPTH-1:0]     seen_match;
  dtpq_pkg::entry_t          qent   [QUEUE_DEPTH];
  dtpq_pkg::qcell_ctl_t      qctl   [QUEUE_DEPTH];

  // Step decisions
  logic              dup;
  logic              do_ins;
  logic              do_pop;
  logic              do_rec;
  logic              full;
  logic [QCW-1:0]    pos;
  logic              evict_urg;
  logic [QCW:0]      ucnt_sum;
  logic              head_urg;
  dtpq_pkg::entry_t  popped;
  logic [dtpq_pkg::LEVEL_W-1:0] level;

  assign s_axis_tready = (state_q == dtpq_pkg::S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign upd           = (state_q == dtpq_pkg::S_UPD);

  // Capture the item; the seen cells compare against the live bus this cycle.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.id  <= s_axis_tdata[63:0];
      in_q.idv <= s_axis_tdata[64];
      in_q.urg <= s_axis_tdata[65];
      in_q.tag <= s_axis_tdata[81:66];
      in_q.dbm <= s_axis_tdata[90:82];
      op_q     <= dtpq_pkg::op_e'(s_axis_tuser);
    end
  end

  // Seen window: newest ID in cell 0, oldest in cell scnt_q - 1.
  for (genvar k = 0; k < SEEN_DEPTH; k++) begin : g_seen
    logic [dtpq_pkg::ID_W-1:0] prev_id;
    if (k == 0) begin : g_first
      assign prev_id = in_q.id;
    end else begin : g_rest
      assign prev_id = seen_id[k-1];
    end
    dtpq_seen_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmp_id_i  (s_axis_tdata[63:0]),
      .active_i  (scnt_q > SCW'(k)),
      .shift_i   (do_rec),
      .prev_id_i (prev_id),
      .id_o      (seen_id[k]),
      .match_o   (seen_match[k])
    );
  end

  // Decisions for the update cycle
  assign dup      = in_q.idv && (|seen_match);
  assign do_ins   = upd && (op_q == dtpq_pkg::OP_RECV) && !dup;
  assign do_pop   = upd && (op_q == dtpq_pkg::OP_POP) && (qcnt_q != '0);
  assign do_rec   = do_ins && in_q.idv;
  assign full     = (qcnt_q == QCW'(QUEUE_DEPTH));
  assign pos      = in_q.urg ? ucnt_q : qcnt_q;
  assign evict_urg = (pos == QCW'(QUEUE_DEPTH)) ? in_q.urg : qent[QUEUE_DEPTH-1].urg;
  assign ucnt_sum = {1'b0, ucnt_q} + {{QCW{1'b0}}, in_q.urg};
  assign popped   = qent[0];

  // Queue row: insert shifts toward the tail, pop shifts toward the head.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_queue
    dtpq_pkg::entry_t prev_e;
    dtpq_pkg::entry_t next_e;
    if (k == 0) begin : g_first
      assign prev_e = qent[0];
    end else begin : g_prev
      assign prev_e = qent[k-1];
    end
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = qent[k];
    end else begin : g_next
      assign next_e = qent[k+1];
    end
    assign qctl[k].load_new  = do_ins && (pos == QCW'(k));
    assign qctl[k].take_prev = do_ins && (pos < QCW'(k));
    assign qctl[k].take_next = do_pop && (k < QUEUE_DEPTH - 1);
    dtpq_queue_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (qctl[k]),
      .new_i   (in_q),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .entry_o (qent[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    qcnt_d      = qcnt_q;
    ucnt_d      = ucnt_q;
    scnt_d      = scnt_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    out_data_d  = out_data_q;
    head_urg    = qent[0].urg;
    level       = dtpq_pkg::LEVEL_W'(qcnt_q);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dtpq_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = dtpq_pkg::S_UPD;
        end
      end
      dtpq_pkg::S_UPD: begin
        state_d = dtpq_pkg::S_IDLE;
        if (op_q == dtpq_pkg::OP_RECV) begin
          if (dup) begin
            status_d = dtpq_pkg::ST_DUPLICATE;
          end else begin
            if (in_q.idv && (scnt_q != SCW'(SEEN_DEPTH))) begin
              scnt_d = scnt_q + SCW'(1);
            end
            head_urg = (pos == '0) ? in_q.urg : qent[0].urg;
            if (full) begin
              // Drop the tail: either the new item or the old last one.
              status_d = (pos == QCW'(QUEUE_DEPTH)) ? dtpq_pkg::ST_NEW_DROPPED
                                                    : dtpq_pkg::ST_EVICTED;
              ucnt_d   = (evict_urg && (ucnt_sum != '0)) ? QCW'(ucnt_sum - 1'b1)
                                                         : QCW'(ucnt_sum);
            end else begin
              status_d = dtpq_pkg::ST_QUEUED;
              qcnt_d   = qcnt_q + QCW'(1);
              ucnt_d   = QCW'(ucnt_sum);
            end
          end
        end else if (qcnt_q == '0) begin
          status_d = dtpq_pkg::ST_EMPTY;
        end else begin
          status_d = dtpq_pkg::ST_POPPED;
          qcnt_d   = qcnt_q - QCW'(1);
          head_urg = qent[1].urg;
          if (popped.urg && (ucnt_q != '0)) begin
            ucnt_d = ucnt_q - QCW'(1);
          end
        end

        level = dtpq_pkg::LEVEL_W'(qcnt_d);
        out_data_d = '0;
        if (do_pop) begin
          out_data_d[63:0]  = popped.id;
          out_data_d[64]    = popped.idv;
          out_data_d[65]    = popped.urg;
          out_data_d[81:66] = popped.tag;
          out_data_d[90:82] = popped.dbm;
        end
        out_data_d[95:91] = level;
        out_data_d[96]    = (qcnt_d != '0) && head_urg;
        out_valid_d       = 1'b1;
      end
      default: begin
        state_d = dtpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtpq_pkg::S_IDLE;
      qcnt_q      <= '0;
      ucnt_q      <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      qcnt_q      <= qcnt_d;
      ucnt_q      <= ucnt_d;
      scnt_q      <= scnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_data_q <= out_data_d;
      status_q   <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = status_q;

  // Urgent items form the front of the queue, so never more than the count.
  a_ucnt_le_qcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucnt_q <= qcnt_q)
    else $error("urgent count exceeds queue count");

  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_scnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= SCW'(SEEN_DEPTH))
    else $error("seen count beyond depth");

  // A result appears only from an update cycle.
  a_result_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == dtpq_pkg::S_UPD))
    else $error("result raised outside update cycle");

  // Each update leaves a result pending.
  a_upd_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtpq_pkg::S_UPD) |=> m_axis_tvalid)
    else $error("update cycle produced no result");

endmodule

FILE: rtl/dtpq_seen_cell.sv
module dtpq_seen_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dtpq_pkg::ID_W-1:0]  cmp_id_i,
  input  logic                       active_i,
  input  logic                       shift_i,
  input  logic [dtpq_pkg::ID_W-1:0]  prev_id_i,
  output logic [dtpq_pkg::ID_W-1:0]  id_o,
  output logic                       match_o
);

  logic [dtpq_pkg::ID_W-1:0] id_q;
  logic                      match_q;
  logic                      match_d;

  assign match_d = active_i && (id_q == cmp_id_i);

  // Stored ID carries no reset; it is only read while the cell is active.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q <= prev_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign id_o    = id_q;
  assign match_o = match_q;

endmodule

FILE: rtl/dtpq_queue_cell.sv
module dtpq_queue_cell (
  input  logic                 clk_i,
  input  dtpq_pkg::qcell_ctl_t ctl_i,
  input  dtpq_pkg::entry_t     new_i,
  input  dtpq_pkg::entry_t     prev_i,
  input  dtpq_pkg::entry_t     next_i,
  output dtpq_pkg::entry_t     entry_o
);

  dtpq_pkg::entry_t entry_q;
  dtpq_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load_new) begin
      entry_d = new_i;
    end else if (ctl_i.take_prev) begin
      entry_d = prev_i;
    end else if (ctl_i.take_next) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
